// ===== src/sst_pkg.sv =====
// Shared types, sizes and operation codes for the sorted set table.
package sst_pkg;

  // Number of key slots in the cell row.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ECNT_W   = 7;
  // Count register wide enough for CAPACITY itself, never narrower than the result field.
  localparam int unsigned CNT_RAW  = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W    = (CNT_RAW > ECNT_W) ? CNT_RAW : ECNT_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_MEMBER = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Input item.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic              success;
    logic              full_res;
    logic [ECNT_W-1:0] entry_count;
  } out_item_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } slot_t;

  // Lookup status of the whole row.
  typedef struct packed {
    logic hit;
  } row_stat_t;

endpackage

// ===== src/sorted_set_table.sv =====
// Top level of the sorted set table: handshake, count and result register.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | in_valid_i / in_stall_o   | in_item_i  (op, key)
//  out      | output    | out_valid_o / out_stall_i | out_item_o (success, full_res,
//           |           |                           |             entry_count)
//
// One item per cycle while in_stall_o is low: every cell compares its key and shifts in the same cycle,
// and the result shows in the cycle after the item is taken.
// Reset empties the store at once; no clearing pass is needed.
// A held result stalls the input only while out_stall_i is high.
module sorted_set_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sst_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sst_pkg::out_item_t out_item_o
);

  logic                       accept;
  logic                       out_valid_q;
  sst_pkg::out_item_t         out_q, res;
  logic [sst_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       full;
  sst_pkg::cmd_t              cmd;
  sst_pkg::row_stat_t         stat;

  // Take an item unless a result is waiting and stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == sst_pkg::CNT_W'(sst_pkg::CAPACITY));

  // Decide the row command from the lookup.
  always_comb begin
    cmd.key = in_item_i.key;
    cmd.ins = accept && (in_item_i.op == sst_pkg::OP_INSERT) && !stat.hit && !full;
    cmd.del = accept && (in_item_i.op == sst_pkg::OP_DELETE) && stat.hit;
  end

  sst_row u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // Advance the count and build the result.
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + sst_pkg::CNT_W'(1);
    end else if (cmd.del) begin
      count_d = count_q - sst_pkg::CNT_W'(1);
    end
    res.full_res    = (in_item_i.op == sst_pkg::OP_INSERT) && !stat.hit && full;
    res.entry_count = count_d[sst_pkg::ECNT_W-1:0];
    case (in_item_i.op)
      sst_pkg::OP_MEMBER: res.success = stat.hit;
      sst_pkg::OP_INSERT: res.success = !stat.hit && !full;
      sst_pkg::OP_DELETE: res.success = stat.hit;
      default:            res.success = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until it is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/sst_cell.sv =====
// One slot of the sorted row: holds a key, compares it, and shifts with its neighbors.
module sst_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sst_pkg::cmd_t  cmd_i,
  input  sst_pkg::slot_t left_i,
  input  logic           left_lt_i,
  input  sst_pkg::slot_t right_i,
  output sst_pkg::slot_t slot_o,
  output logic           lt_o,
  output logic           eq_o
);

  logic                            valid_q, valid_d;
  logic signed [sst_pkg::KEY_W-1:0] key_q, key_d;

  // Compare the held key against the broadcast key.
  assign lt_o   = valid_q && (key_q < cmd_i.key);
  assign eq_o   = valid_q && (key_q == cmd_i.key);
  assign slot_o = '{valid: valid_q, key: key_q};

  // Insert shifts right past the insertion point; delete shifts left.
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (cmd_i.ins) begin
      valid_d = valid_q | left_i.valid;
      if (!lt_o) begin
        key_d = left_lt_i ? cmd_i.key : left_i.key;
      end
    end else if (cmd_i.del) begin
      valid_d = right_i.valid;
      if (!lt_o) begin
        key_d = right_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Key payload carries no reset.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ===== src/sst_row.sv =====
// Row of key cells chained left to right, with the match reduction.
module sst_row (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sst_pkg::cmd_t      cmd_i,
  output sst_pkg::row_stat_t stat_o
);

  localparam int unsigned N = sst_pkg::CAPACITY;

  sst_pkg::slot_t slot [N];
  logic [N-1:0]   lt;
  logic [N-1:0]   eq;

  // Chain the cells; the left edge acts as minus infinity, the right edge as empty.
  for (genvar i = 0; i < N; i++) begin : g_cell
    sst_pkg::slot_t left_s;
    sst_pkg::slot_t right_s;
    logic           left_lt;

    if (i == 0) begin : g_first
      assign left_s  = '{valid: 1'b1, key: cmd_i.key};
      assign left_lt = 1'b1;
    end else begin : g_mid_l
      assign left_s  = slot[i-1];
      assign left_lt = lt[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_s = '{valid: 1'b0, key: cmd_i.key};
    end else begin : g_mid_r
      assign right_s = slot[i+1];
    end

    sst_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .left_i    (left_s),
      .left_lt_i (left_lt),
      .right_i   (right_s),
      .slot_o    (slot[i]),
      .lt_o      (lt[i]),
      .eq_o      (eq[i])
    );
  end

  // Keys are distinct, so at most one cell matches.
  assign stat_o.hit = |eq;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the sorted set table: queued stimulus, shadow set, result scoreboard.
`timescale 1ns / 100ps

module tb;

  // Reserved operation code: changes nothing.
  localparam logic [sst_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned POOL_N    = 96;
  localparam int unsigned SEG_LEN   = 150;
  localparam int unsigned SEG_N     = 12;
  localparam int unsigned PHASE_LEN = 225;
  localparam int unsigned STUCK_MAX = 4000;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  sst_pkg::in_item_t  in_item_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  sst_pkg::out_item_t out_item_o;

  sorted_set_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Shadow copy of the set, kept packed and ascending.
  logic signed [sst_pkg::KEY_W-1:0] set_keys [sst_pkg::CAPACITY];
  int unsigned set_size = 0;

  sst_pkg::in_item_t  ops_to_send [$];
  sst_pkg::out_item_t set_answers [$];
  int unsigned items_queued = 0;
  logic [1:0]  idle_phase;
  int unsigned stuck_cycles = 0;
  int unsigned errors       = 0;
  int unsigned checked      = 0;
  int unsigned found_hits   = 0;
  int unsigned full_refusals = 0;
  int unsigned peak_size    = 0;

  // Apply one operation to the shadow set and return the result it yields.
  function automatic sst_pkg::out_item_t apply_to_set(sst_pkg::in_item_t it);
    sst_pkg::out_item_t r;
    int unsigned        pos;
    logic               hit;
    r = '0;
    pos = 0;
    while (pos < set_size && $signed(set_keys[pos]) < $signed(it.key)) pos++;
    hit = (pos < set_size) && (set_keys[pos] == it.key);
    case (it.op)
      sst_pkg::OP_MEMBER: begin
        r.success = hit;
        if (hit) found_hits++;
      end
      sst_pkg::OP_INSERT: begin
        if (!hit) begin
          if (set_size >= sst_pkg::CAPACITY) begin
            r.full_res = 1'b1;
            full_refusals++;
          end else begin
            for (int i = set_size; i > pos; i--) set_keys[i] = set_keys[i-1];
            set_keys[pos] = it.key;
            set_size++;
            r.success = 1'b1;
          end
        end
      end
      sst_pkg::OP_DELETE: begin
        if (hit) begin
          for (int i = pos; i + 1 < set_size; i++) set_keys[i] = set_keys[i+1];
          set_size--;
          r.success = 1'b1;
        end
      end
      default: ;
    endcase
    if (set_size > peak_size) peak_size = set_size;
    r.entry_count = set_size[sst_pkg::ECNT_W-1:0];
    return r;
  endfunction

  function automatic sst_pkg::in_item_t make_op(logic [sst_pkg::OP_W-1:0] op,
                                                logic [sst_pkg::KEY_W-1:0] key);
    sst_pkg::in_item_t it;
    it.op  = op;
    it.key = key;
    return it;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Driver: present queued items, with random gaps depending on the idle phase.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned idle_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      idle_phase <= 2'd0;
    end else begin
      idle_phase <= 2'(((items_queued - ops_to_send.size()) / PHASE_LEN) % 4);
      case (idle_phase)
        2'd1:    idle_pct = 83;
        2'd3:    idle_pct = 37;
        default: idle_pct = 0;
      endcase
      if (!in_valid_i || !in_stall_o) begin
        if (ops_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= ops_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random depending on the idle phase.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall_pct;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      case (idle_phase)
        2'd2:    stall_pct = 83;
        2'd3:    stall_pct = 37;
        default: stall_pct = 0;
      endcase
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk_i) begin
    sst_pkg::out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) set_answers.push_back(apply_to_set(in_item_i));
      if (out_valid_o && !out_stall_i) begin
        checked++;
        if (set_answers.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tb: result %0d with nothing pending: success=%0b full=%0b count=%0d",
                     checked, out_item_o.success, out_item_o.full_res,
                     out_item_o.entry_count);
        end else begin
          want = set_answers.pop_front();
          if (out_item_o.success !== want.success || out_item_o.full_res !== want.full_res ||
              out_item_o.entry_count !== want.entry_count) begin
            errors++;
            if (errors <= 10)
              $display("tb: result %0d mismatch: want %0b %0b %0d, got %0b %0b %0d",
                       checked, want.success, want.full_res, want.entry_count,
                       out_item_o.success, out_item_o.full_res, out_item_o.entry_count);
          end
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_MAX) begin
        $display("tb: no progress for %0d cycles, %0d results pending", STUCK_MAX,
                 set_answers.size());
        $display("tb: done, errors");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic signed [sst_pkg::KEY_W-1:0] key_pool [POOL_N];
    logic [sst_pkg::KEY_W-1:0]        k;
    logic [sst_pkg::OP_W-1:0]         op;
    int unsigned                      r;

    // Directed: empty store, extremes, duplicates, removal at head, middle and tail.
    ops_to_send.push_back(make_op(sst_pkg::OP_MEMBER, 32'h0000_0000));
    ops_to_send.push_back(make_op(sst_pkg::OP_DELETE, 32'h0000_0005));
    ops_to_send.push_back(make_op(OP_RESERVED,        32'h0000_0000));
    ops_to_send.push_back(make_op(sst_pkg::OP_INSERT, 32'h8000_0000));
    ops_to_send.push_back(make_op(sst_pkg::OP_INSERT, 32'h7fff_ffff));
    ops_to_send.push_back(make_op(sst_pkg::OP_INSERT, 32'h0000_0000));
    ops_to_send.push_back(make_op(sst_pkg::OP_INSERT, 32'hffff_ffff));
    ops_to_send.push_back(make_op(sst_pkg::OP_INSERT, 32'h0000_0001));
    ops_to_send.push_back(make_op(sst_pkg::OP_INSERT, 32'h8000_0000));
    ops_to_send.push_back(make_op(sst_pkg::OP_MEMBER, 32'h7fff_ffff));
    ops_to_send.push_back(make_op(sst_pkg::OP_MEMBER, 32'h0000_0002));
    ops_to_send.push_back(make_op(sst_pkg::OP_DELETE, 32'hffff_ffff));
    ops_to_send.push_back(make_op(sst_pkg::OP_DELETE, 32'hffff_ffff));
    ops_to_send.push_back(make_op(sst_pkg::OP_MEMBER, 32'hffff_ffff));
    ops_to_send.push_back(make_op(OP_RESERVED,        32'h7fff_ffff));
    ops_to_send.push_back(make_op(sst_pkg::OP_DELETE, 32'h8000_0000));
    ops_to_send.push_back(make_op(sst_pkg::OP_DELETE, 32'h7fff_ffff));
    ops_to_send.push_back(make_op(sst_pkg::OP_INSERT, 32'haaaa_aaaa));
    ops_to_send.push_back(make_op(sst_pkg::OP_INSERT, 32'h5555_5555));
    ops_to_send.push_back(make_op(sst_pkg::OP_MEMBER, 32'h5555_5555));

    // Random: alternate fill-heavy and drain-heavy segments over a key pool,
    // so the store reaches full and empty repeatedly; refresh the pool per pair.
    for (int seg = 0; seg < SEG_N; seg++) begin
      if (seg % 2 == 0) begin
        for (int i = 0; i < POOL_N; i++) begin
          case ($urandom_range(3))
            0:       key_pool[i] = $urandom;
            1:       key_pool[i] = $signed($urandom_range(40)) - 20;
            2:       key_pool[i] = 32'h8000_0000 + $urandom_range(7);
            default: key_pool[i] = 32'h7fff_ffff - $urandom_range(7);
          endcase
        end
      end
      for (int i = 0; i < SEG_LEN; i++) begin
        r = $urandom_range(99);
        if (seg % 2 == 0)
          op = (r < 60) ? sst_pkg::OP_INSERT :
               (r < 78) ? sst_pkg::OP_MEMBER :
               (r < 95) ? sst_pkg::OP_DELETE : OP_RESERVED;
        else
          op = (r < 15) ? sst_pkg::OP_INSERT :
               (r < 35) ? sst_pkg::OP_MEMBER :
               (r < 94) ? sst_pkg::OP_DELETE : OP_RESERVED;
        k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_N-1)];
        ops_to_send.push_back(make_op(op, k));
      end
    end
    items_queued = ops_to_send.size();

    // Hold reset, then release on a clock edge.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: wait until every result has been seen.
    while (checked < items_queued) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d items sent, %0d results checked, %0d mismatches", items_queued, checked,
             errors);
    $display("tb: %0d member hits, %0d inserts refused as full, peak size %0d of %0d",
             found_hits, full_refusals, peak_size, sst_pkg::CAPACITY);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
